// File: hw/rtl/smmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smmf_pkg
// Shared types and constants of the sliding median / mean filter.
// ----------------------------------------------------------------------------
package smmf_pkg;

   localparam int VALUE_W = 32;
   localparam int TIME_W  = 31;

   // pipeline registers from the window register up to, not counting, the output register
   localparam int NUM_STAGES = 6;

   // low chunk width of the two-chunk constant divider
   localparam int DIV_LO_W = 18;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [TIME_W-1:0]         time_type;

   typedef enum logic {
      MODE_MEDIAN = 1'b0,
      MODE_MEAN   = 1'b1
   } filter_mode_type;

   // load enables of the divider stages
   typedef struct packed {
      logic abs_en;
      logic hi_en;
      logic fold_en;
      logic lo_en;
   } div_en_type;

endpackage

// File: hw/rtl/smmf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smmf channel interfaces
// Valid/ready channels for samples, results and the mode register write.
// ----------------------------------------------------------------------------
interface smmf_req_if;
   import smmf_pkg::*;
   logic      valid;
   logic      ready;
   value_type sample_value;
   time_type  sample_time;
   logic      series_start;

   modport source (output valid, sample_value, sample_time, series_start, input ready);
   modport sink (input valid, sample_value, sample_time, series_start, output ready);
endinterface

interface smmf_rsp_if;
   import smmf_pkg::*;
   logic      valid;
   logic      ready;
   value_type filtered_value;
   time_type  center_time;

   modport source (output valid, filtered_value, center_time, input ready);
   modport sink (input valid, filtered_value, center_time, output ready);
endinterface

interface smmf_csr_if;
   logic valid;
   logic ready;
   logic filter_mode;

   modport source (output valid, filter_mode, input ready);
   modport sink (input valid, filter_mode, output ready);
endinterface

// File: hw/rtl/smmf_median.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smmf_median
// Rank network: picks the window sample whose stable sorted rank is the middle.
// ----------------------------------------------------------------------------
module smmf_median #(
   parameter int WINDOW_LEN = 5
) (
   input  smmf_pkg::value_type win_in [WINDOW_LEN],
   output smmf_pkg::value_type median
);
   import smmf_pkg::*;

   localparam int CNT_W   = $clog2(WINDOW_LEN);
   localparam int MED_POS = (WINDOW_LEN - 1) / 2;
   localparam logic [CNT_W-1:0] MED_RANK = CNT_W'(MED_POS);

   logic [CNT_W-1:0] rank [WINDOW_LEN];

   always_comb begin
      median = '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
         rank[i] = '0;
         for (int j = 0; j < WINDOW_LEN; j++) begin
            // ties broken by position so every rank is taken exactly once
            if ((j != i) && ((win_in[j] < win_in[i]) ||
                             ((j < i) && (win_in[j] == win_in[i])))) begin
               rank[i] = rank[i] + 1'b1;
            end
         end
      end
      for (int i = 0; i < WINDOW_LEN; i++) begin
         if (rank[i] == MED_RANK) begin
            median = median | win_in[i];
         end
      end
   end

endmodule

// File: hw/rtl/smmf_mean_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smmf_mean_div
// Four-stage divide of the window sum by the window length, toward zero.
// ----------------------------------------------------------------------------
module smmf_mean_div #(
   parameter int WINDOW_LEN = 5
) (
   input  logic                                                clock,
   input  smmf_pkg::div_en_type                                en,
   input  logic signed [smmf_pkg::VALUE_W+$clog2(WINDOW_LEN)-1:0] sum_in,
   output smmf_pkg::value_type                                 mean_out
);
   import smmf_pkg::*;

   localparam int LOG_W = $clog2(WINDOW_LEN);
   localparam int SUM_W = VALUE_W + LOG_W;
   localparam int MAG_W = SUM_W;
   localparam int LO_W  = DIV_LO_W;
   localparam int HI_W  = MAG_W - LO_W;
   localparam int XL_W  = LO_W + LOG_W;
   localparam int KH    = HI_W + LOG_W;
   localparam int KL    = XL_W + LOG_W;
   localparam int RH_W  = HI_W + 1;
   localparam int RL_W  = XL_W + 1;
   localparam int PH_W  = KH + HI_W;
   localparam int PL_W  = KL + LO_W;
   localparam longint unsigned RH_L = ((64'd1 << KH) + WINDOW_LEN - 1) / WINDOW_LEN;
   localparam longint unsigned RL_L = ((64'd1 << KL) + WINDOW_LEN - 1) / WINDOW_LEN;
   localparam logic [RH_W-1:0] RH = RH_W'(RH_L);
   localparam logic [RL_W-1:0] RL = RL_W'(RL_L);
   localparam logic [HI_W-1:0] DIVISOR = HI_W'(WINDOW_LEN);

   logic [MAG_W-1:0] mag_a_ff;
   logic             neg_a_ff;
   logic [HI_W-1:0]  qh_b_ff;
   logic [HI_W-1:0]  mh_b_ff;
   logic [LO_W-1:0]  ml_b_ff;
   logic             neg_b_ff;
   logic [XL_W-1:0]  x_c_ff;
   logic [HI_W-1:0]  qh_c_ff;
   logic             neg_c_ff;
   logic [LO_W-1:0]  ql_d_ff;
   logic [HI_W-1:0]  qh_d_ff;
   logic             neg_d_ff;

   logic [PH_W-1:0]  prod_h;
   logic [PL_W-1:0]  prod_l;
   logic [HI_W-1:0]  rem_h;
   logic [MAG_W-1:0] quo;
   logic [MAG_W-1:0] res;

   // reciprocal multiplies are exact over the chunk ranges, no correction step
   assign prod_h = PH_W'(mag_a_ff[MAG_W-1 -: HI_W]) * PH_W'(RH);
   assign rem_h  = mh_b_ff - (qh_b_ff * DIVISOR);
   assign prod_l = PL_W'(x_c_ff) * PL_W'(RL);
   assign quo    = {qh_d_ff, ql_d_ff};
   assign res    = neg_d_ff ? (MAG_W'(0) - quo) : quo;
   assign mean_out = value_type'(res[VALUE_W-1:0]);

   always_ff @(posedge clock) begin
      if (en.abs_en) begin
         neg_a_ff <= sum_in[SUM_W-1];
         mag_a_ff <= sum_in[SUM_W-1] ? MAG_W'(-sum_in) : MAG_W'(sum_in);
      end
      if (en.hi_en) begin
         qh_b_ff  <= prod_h[KH +: HI_W];
         mh_b_ff  <= mag_a_ff[MAG_W-1 -: HI_W];
         ml_b_ff  <= mag_a_ff[LO_W-1:0];
         neg_b_ff <= neg_a_ff;
      end
      if (en.fold_en) begin
         // remainder of the high chunk is below the divisor
         x_c_ff   <= {rem_h[LOG_W-1:0], ml_b_ff};
         qh_c_ff  <= qh_b_ff;
         neg_c_ff <= neg_b_ff;
      end
      if (en.lo_en) begin
         ql_d_ff  <= prod_l[KL +: LO_W];
         qh_d_ff  <= qh_c_ff;
         neg_d_ff <= neg_c_ff;
      end
   end

endmodule

// File: hw/rtl/sliding_median_mean_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_median_mean_filter
// Five-sample (WINDOW_LEN) sliding median or mean of timestamped samples.
// ----------------------------------------------------------------------------
// Takes one sample per clock while the pipeline is not backed up, and gives
// one result per sample once the window of a series is full; the first
// WINDOW_LEN-1 samples of a series give none. A sample goes through the window
// register, loaded at the accepting edge, the rank network and window sum
// register, four divider stages and the output register. Every stage has its
// own valid and moves up when the next one is free, so bubbles close up and
// samples keep flowing while a result waits at the output, until all are full.
// The mode register selects median (0) or truncated mean (1). The user must
// write it only while no sample is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module sliding_median_mean_filter #(
   parameter int WINDOW_LEN = 5
) (
   input  logic        clock,
   input  logic        reset,
   smmf_req_if.sink    req_bus,
   smmf_rsp_if.source  rsp_bus,
   smmf_csr_if.sink    csr_bus
);
   import smmf_pkg::*;

   localparam int HIST_LEN = WINDOW_LEN - 1;
   localparam int TIME_LEN = WINDOW_LEN / 2;
   localparam int FILL_W   = $clog2(WINDOW_LEN);
   localparam int SUM_W    = VALUE_W + $clog2(WINDOW_LEN);
   localparam logic [FILL_W-1:0] HIST_CNT = FILL_W'(HIST_LEN);

   // sample history, oldest first
   value_type hist_val_ff [HIST_LEN];
   time_type  hist_time_ff [TIME_LEN];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] fill_base;
   logic              win_full;
   logic              req_fire;

   filter_mode_type filter_mode_ff, filter_mode_in;

   logic [NUM_STAGES-1:0] vld_ff, vld_in;
   logic [NUM_STAGES:0]   rdy;
   logic [NUM_STAGES:0]   load;

   value_type win_ff [WINDOW_LEN];
   value_type win_new [WINDOW_LEN];
   time_type  tim_ff [0:NUM_STAGES-1];
   value_type med_ff [1:NUM_STAGES-1];
   value_type med_val;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   value_type mean_val;
   div_en_type div_en;

   logic      rsp_valid_ff, rsp_valid_in;
   value_type rsp_value_ff, rsp_value_in;
   time_type  rsp_time_ff;

   // ready ripples back from the output register
   always_comb begin
      rdy[NUM_STAGES] = !rsp_valid_ff || rsp_bus.ready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign req_fire  = req_bus.valid && rdy[0];
   assign fill_base = req_bus.series_start ? '0 : fill_ff;
   assign win_full  = fill_base >= HIST_CNT;

   always_comb begin
      fill_in = fill_ff;
      if (req_fire) begin
         fill_in = win_full ? fill_base : fill_base + 1'b1;
      end
   end

   always_comb begin
      for (int i = 0; i < HIST_LEN; i++) begin
         win_new[i] = hist_val_ff[i];
      end
      win_new[HIST_LEN] = req_bus.sample_value;
   end

   always_comb begin
      load[0]   = req_fire && win_full;
      vld_in[0] = rdy[0] ? (req_fire && win_full) : vld_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         load[k]   = rdy[k] && vld_ff[k-1];
         vld_in[k] = rdy[k] ? vld_ff[k-1] : vld_ff[k];
      end
      load[NUM_STAGES] = rdy[NUM_STAGES] && vld_ff[NUM_STAGES-1];
      rsp_valid_in     = rdy[NUM_STAGES] ? vld_ff[NUM_STAGES-1] : rsp_valid_ff;
   end

   always_comb begin
      filter_mode_in = filter_mode_ff;
      if (csr_bus.valid) begin
         filter_mode_in = filter_mode_type'(csr_bus.filter_mode);
      end
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
         sum_in = sum_in + SUM_W'(win_ff[i]);
      end
   end

   smmf_median #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_median (
      .win_in (win_ff),
      .median (med_val)
   );

   assign div_en.abs_en  = load[2];
   assign div_en.hi_en   = load[3];
   assign div_en.fold_en = load[4];
   assign div_en.lo_en   = load[5];

   smmf_mean_div #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_mean_div (
      .clock    (clock),
      .en       (div_en),
      .sum_in   (sum_ff),
      .mean_out (mean_val)
   );

   assign rsp_value_in = (filter_mode_ff == MODE_MEAN) ? mean_val : med_ff[NUM_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff        <= '0;
         vld_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         filter_mode_ff <= MODE_MEDIAN;
      end else begin
         fill_ff        <= fill_in;
         vld_ff         <= vld_in;
         rsp_valid_ff   <= rsp_valid_in;
         filter_mode_ff <= filter_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < HIST_LEN - 1; i++) begin
            hist_val_ff[i] <= hist_val_ff[i+1];
         end
         hist_val_ff[HIST_LEN-1] <= req_bus.sample_value;
         for (int i = 0; i < TIME_LEN - 1; i++) begin
            hist_time_ff[i] <= hist_time_ff[i+1];
         end
         hist_time_ff[TIME_LEN-1] <= req_bus.sample_time;
      end
      if (load[0]) begin
         win_ff    <= win_new;
         tim_ff[0] <= hist_time_ff[0];
      end
      if (load[1]) begin
         sum_ff    <= sum_in;
         med_ff[1] <= med_val;
         tim_ff[1] <= tim_ff[0];
      end
      for (int k = 2; k < NUM_STAGES; k++) begin
         if (load[k]) begin
            med_ff[k] <= med_ff[k-1];
            tim_ff[k] <= tim_ff[k-1];
         end
      end
      if (load[NUM_STAGES]) begin
         rsp_value_ff <= rsp_value_in;
         rsp_time_ff  <= tim_ff[NUM_STAGES-1];
      end
   end

   assign req_bus.ready          = rdy[0];
   assign csr_bus.ready          = 1'b1;
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.filtered_value = rsp_value_ff;
   assign rsp_bus.center_time    = rsp_time_ff;

endmodule

// File: hw/rtl/smmf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smmf_checker
// Port-level checks of the filter, bound to the top level.
// ----------------------------------------------------------------------------
module smmf_checker #(
   parameter int WINDOW_LEN = 5
) (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                req_start,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input smmf_pkg::value_type rsp_value,
   input smmf_pkg::time_type  rsp_time
);
   import smmf_pkg::*;

   localparam int FILL_W = $clog2(WINDOW_LEN);
   localparam logic [FILL_W-1:0] HIST_CNT = FILL_W'(WINDOW_LEN - 1);
   localparam logic [3:0] PEND_MAX = 4'(NUM_STAGES + 1);

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [3:0]        pend_ff, pend_in;
   logic [FILL_W-1:0] fill_base;
   logic              req_fire;
   logic              rsp_fire;
   logic              counts;

   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign fill_base = req_start ? '0 : fill_ff;
   assign counts    = req_fire && (fill_base >= HIST_CNT);

   always_comb begin
      fill_in = fill_ff;
      if (req_fire) begin
         fill_in = (fill_base >= HIST_CNT) ? fill_base : fill_base + 1'b1;
      end
      pend_in = pend_ff + {3'b000, counts} - {3'b000, rsp_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         pend_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         pend_ff <= pend_in;
      end
   end

   a_empty_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_time))
      else $error("stalled result changed or dropped");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 4'd0)
      else $error("result without a full-window request");

   a_in_flight_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= PEND_MAX)
      else $error("more requests in flight than pipeline registers");

endmodule

bind sliding_median_mean_filter smmf_checker #(
   .WINDOW_LEN (WINDOW_LEN)
) u_smmf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .req_start (req_bus.series_start),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_value (rsp_bus.filtered_value),
   .rsp_time  (rsp_bus.center_time)
);
